[hw/rtl/imps_pkg.sv]
`timescale 1ns / 1ps
package imps_pkg;
    localparam int QUEUE_DEPTH = 8;
    localparam int QW = $clog2(QUEUE_DEPTH + 1);
    localparam int QI = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_ADDR  = 3'd2,
        ACT_SEND  = 3'd3,
        ACT_RECV  = 3'd4,
        ACT_STOP  = 3'd5,
        ACT_RESET = 3'd6
    } action_t;

    typedef struct packed {
        logic [7:0] tag;
        logic [7:0] addr;
        logic [7:0] len;
        logic [7:0] urg;
    } entry_t;

    typedef struct packed {
        logic       mode;
        entry_t     cmd;
        logic [4:0] status;
        logic [7:0] rx;
    } item_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] address_byte;
        logic [7:0] buffer_index;
        logic [7:0] active_tag;
        logic       store_enable;
        logic [7:0] store_byte;
        logic       done_res;
        logic [7:0] done_tag;
        logic       rejected;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_OUT
    } state_t;
endpackage

[hw/rtl/imps_front.sv]
`timescale 1ns / 1ps
// two-entry item queue between the port and the sequencer
module imps_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  imps_pkg::item_t in_item,
    output logic            q_valid,
    input  logic            q_take,
    output imps_pkg::item_t q_item
);
    import imps_pkg::*;

    item_t      slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_ptr;
    logic       do_push;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign wr_ptr  = rd_reg ^ cnt_reg[0];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, q_take};
        rd_next  = rd_reg ^ q_take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr] <= in_item;
    end
endmodule

[hw/rtl/imps_back.sv]
`timescale 1ns / 1ps
module imps_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_take,
    input  imps_pkg::item_t   q_item,
    output logic              res_valid,
    input  logic              res_take,
    output imps_pkg::result_t res
);
    import imps_pkg::*;

    state_t        state_reg, state_next;
    entry_t        queue_reg [QUEUE_DEPTH];
    logic [QW-1:0] count_reg, count_next;
    logic [QW-1:0] pos_reg, pos_next;
    logic [QW-1:0] sh_reg, sh_next;
    logic          busy_reg, busy_next;
    entry_t        cur_reg, cur_next;
    logic [7:0]    idx_reg, idx_next;
    item_t         it_reg;
    result_t       res_reg, res_next;
    logic          sh_en, ins_en, ld_it;
    result_t       ev;
    logic          ev_pop;

    assign res_valid = (state_reg == ST_OUT);
    assign res       = res_reg;

    // event decode, done in one step from current command state
    always_comb
    begin
        ev       = '0;
        ev_pop   = 1'b0;
        busy_next = busy_reg;
        cur_next = cur_reg;
        idx_next = idx_reg;
        if (it_reg.mode && busy_reg)
        begin
            unique case (it_reg.status)
                5'h01, 5'h02:
                begin
                    ev.action       = ACT_ADDR;
                    ev.address_byte = cur_reg.addr;
                end
                5'h03, 5'h04, 5'h05, 5'h06:
                begin
                    if (idx_reg < cur_reg.len)
                    begin
                        ev.action       = ACT_SEND;
                        ev.buffer_index = idx_reg;
                        idx_next        = idx_reg + 8'd1;
                    end
                    else
                        ev_pop = 1'b1;
                end
                5'h08: ev.action = ACT_RECV;
                5'h09: ev.action = ACT_START;
                5'h0a, 5'h0b:
                begin
                    if (idx_reg < cur_reg.len)
                    begin
                        ev.store_enable = 1'b1;
                        ev.store_byte   = it_reg.rx;
                        ev.buffer_index = idx_reg;
                        idx_next        = idx_reg + 8'd1;
                    end
                    if (idx_next < cur_reg.len)
                        ev.action = ACT_RECV;
                    else
                        ev_pop = 1'b1;
                end
                default:
                begin
                    ev.action = ACT_RESET;
                    idx_next  = 8'd0;
                end
            endcase
        end
        if (ev_pop)
        begin
            ev.done_res = 1'b1;
            ev.done_tag = cur_reg.tag;
            idx_next    = 8'd0;
            if (count_reg != '0)
            begin
                ev.action = ACT_START;
                cur_next  = queue_reg[0];
            end
            else
            begin
                ev.action = ACT_STOP;
                busy_next = 1'b0;
            end
        end
        if (!it_reg.mode && !busy_reg)
        begin
            busy_next = 1'b1;
            cur_next  = it_reg.cmd;
            idx_next  = 8'd0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (it_reg.mode && busy_reg && ev_pop && count_reg != '0)
                    state_next = ST_SHIFT;
                else if (!it_reg.mode && busy_reg && count_reg < QW'(QUEUE_DEPTH))
                begin
                    if (pos_reg < count_reg && queue_reg[pos_reg[QI-1:0]].urg >= it_reg.cmd.urg)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_SHIFT;
                end
                else
                    state_next = ST_OUT;
            end
            ST_SHIFT:
            begin
                if (it_reg.mode)
                begin
                    if (sh_reg + QW'(1) >= count_reg)
                        state_next = ST_OUT;
                end
                else if (sh_reg <= pos_reg)
                    state_next = ST_OUT;
            end
            ST_OUT: if (res_take) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        q_take     = 1'b0;
        ld_it      = 1'b0;
        pos_next   = pos_reg;
        sh_next    = sh_reg;
        count_next = count_reg;
        res_next   = res_reg;
        sh_en      = 1'b0;
        ins_en     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_take   = q_valid;
                ld_it    = q_valid;
                pos_next = '0;
            end
            ST_SCAN:
            begin
                res_next = '0;
                if (it_reg.mode)
                begin
                    if (busy_reg)
                        res_next = ev;
                    sh_next = QW'(1);
                end
                else if (!busy_reg)
                    res_next.action = ACT_START;
                else if (count_reg >= QW'(QUEUE_DEPTH))
                    res_next.rejected = 1'b1;
                else
                begin
                    pos_next = pos_reg + QW'(1);
                    sh_next  = count_reg;
                end
                res_next.active_tag = busy_next ? cur_next.tag : 8'd0;
            end
            ST_SHIFT:
            begin
                if (it_reg.mode)
                begin
                    if (sh_reg < count_reg)
                        sh_en = 1'b1;
                    sh_next = sh_reg + QW'(1);
                    if (sh_reg + QW'(1) >= count_reg)
                        count_next = count_reg - QW'(1);
                end
                else if (sh_reg > pos_reg)
                begin
                    sh_en   = 1'b1;
                    sh_next = sh_reg - QW'(1);
                end
                else
                begin
                    ins_en     = 1'b1;
                    count_next = count_reg + QW'(1);
                end
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            cur_reg   <= '0;
            idx_reg   <= 8'd0;
            pos_reg   <= '0;
            sh_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sh_reg    <= sh_next;
            // the scan stops at the insertion point
            if (state_reg == ST_SCAN && state_next == ST_SHIFT && !it_reg.mode)
                pos_reg <= pos_reg;
            else
                pos_reg <= pos_next;
            if (state_reg == ST_SCAN)
            begin
                busy_reg <= busy_next;
                cur_reg  <= cur_next;
                idx_reg  <= idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_it)
            it_reg <= q_item;
        res_reg <= res_next;
        if (sh_en)
        begin
            if (it_reg.mode)
                queue_reg[sh_reg[QI-1:0] - QI'(1)] <= queue_reg[sh_reg[QI-1:0]];
            else
                queue_reg[sh_reg[QI-1:0]] <= queue_reg[sh_reg[QI-1:0] - QI'(1)];
        end
        if (ins_en)
            queue_reg[pos_reg[QI-1:0]] <= it_reg.cmd;
    end
endmodule

[hw/rtl/i2c_master_priority_sequencer.sv]
`timescale 1ns / 1ps
// I2C master command sequencer. Items enter a two-deep input queue; the back end
// takes one item at a time and passes it through an idle, a decode and an output state.
// A queued plan also scans the command queue for its insertion point and moves the
// entries behind it in a shift state, and a finish that pops the command queue moves
// the remaining entries up. Results wait in an output register until popped.
// Received bytes go out on store_byte.
module i2c_master_priority_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       mode,
    input  logic [7:0] command_tag,
    input  logic [7:0] address_rw,
    input  logic [7:0] byte_count,
    input  logic [7:0] urgency,
    input  logic [7:0] bus_status,
    input  logic [7:0] received_byte,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] action,
    output logic [7:0] address_byte,
    output logic [7:0] buffer_index,
    output logic [7:0] active_tag,
    output logic       store_enable,
    output logic [7:0] store_byte,
    output logic       done_res,
    output logic [7:0] done_tag,
    output logic       rejected
);
    import imps_pkg::*;

    item_t   in_item, q_item;
    logic    q_valid, q_take, res_valid;
    result_t res;

    assign in_item = '{mode: mode,
                       cmd: '{tag: command_tag, addr: address_rw,
                              len: byte_count, urg: urgency},
                       status: bus_status[7:3], rx: received_byte};

    imps_front u_front (
        .clk, .rst_n, .push, .full, .in_item,
        .q_valid, .q_take, .q_item
    );

    imps_back u_back (
        .clk, .rst_n, .q_valid, .q_take, .q_item,
        .res_valid, .res_take(pop), .res
    );

    assign empty        = !res_valid;
    assign action       = res.action;
    assign address_byte = res.address_byte;
    assign buffer_index = res.buffer_index;
    assign active_tag   = res.active_tag;
    assign store_enable = res.store_enable;
    assign store_byte   = res.store_byte;
    assign done_res     = res.done_res;
    assign done_tag     = res.done_tag;
    assign rejected     = res.rejected;

    a_store_no_done_reject: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(rejected && (store_enable || done_res)))
        else $error("reject with event fields");
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped");
    a_done_action: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && done_res) |-> (action == ACT_START || action == ACT_STOP))
        else $error("done without start or stop");
endmodule
